[rtl/fsm_pkg.sv]
// ----------------------------------------------------------------------------
// fsm_pkg: shared types and constants of the frame slot manager.
// Holds slot states, command and status codes and the controller interface.
// ----------------------------------------------------------------------------
package fsm_pkg;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned CntW     = 5;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_READY   = 2'd1,
    SLOT_READING = 2'd2
  } slot_state_e;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_DROPPED = 2'd1,
    STS_NOFRAME = 2'd2,
    STS_IGNORED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ADDR_INIT_SLOTS = 2'd0,
    ADDR_BUDGET     = 2'd1,
    ADDR_RECORDING  = 2'd2
  } reg_addr_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // latch the request, clear scan accumulators
    logic scan;      // evaluate slot at the scan index
    logic prepare;   // decide growth or drop for a write
    logic commit;    // apply the command result to the slot store
    logic stat;      // sum one slot into the statistics
    logic finish;    // latch the result item
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic stat_last;
  } dp_sts_t;

  function automatic logic [CntW-1:0] clamp_slots(input logic [CntW-1:0] v);
    if (v == '0) begin
      return CntW'(1);
    end
    if (v > CntW'(NumSlots)) begin
      return CntW'(NumSlots);
    end
    return v;
  endfunction

endpackage

[rtl/fsm_ctrl.sv]
// ----------------------------------------------------------------------------
// fsm_ctrl: command sequencer of the frame slot manager.
// Steps through statistics, growth decision, slot scan, commit and statistics.
// ----------------------------------------------------------------------------
module fsm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_free_i,
  input  fsm_pkg::dp_sts_t sts_i,
  output fsm_pkg::dp_cmd_t cmd_o,
  output logic            busy_o
);
  import fsm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN1  = 7'b0000010,
    S_PREP   = 7'b0000100,
    S_SCAN2  = 7'b0001000,
    S_COMMIT = 7'b0010000,
    S_STAT   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd_o.stat = 1'b1;
        if (sts_i.stat_last) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prepare = 1'b1;
        state_d       = S_SCAN2;
      end
      S_SCAN2: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_STAT;
      end
      S_STAT: begin
        cmd_o.stat = 1'b1;
        if (sts_i.stat_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

[rtl/fsm_dp.sv]
// ----------------------------------------------------------------------------
// fsm_dp: slot store, scan units, counters and result register.
// One slot is examined per cycle for both searches and the statistics.
// ----------------------------------------------------------------------------
module fsm_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fsm_pkg::dp_cmd_t cmd_i,
  output fsm_pkg::dp_sts_t sts_o,
  input  logic [1:0]       command_i,
  input  logic [31:0]      frame_sequence_i,
  input  logic [47:0]      frame_time_i,
  input  logic [23:0]      frame_bytes_i,
  input  logic [3:0]       release_slot_i,
  input  logic             cfg_slots_we_i,
  input  logic [4:0]       cfg_slots_i,
  input  logic [31:0]      byte_budget_i,
  input  logic             recording_i,
  output logic [190:0]     result_o
);
  import fsm_pkg::*;

  logic [1:0]  st_q   [NumSlots];
  logic [7:0]  rd_q   [NumSlots];
  logic [31:0] seq_q  [NumSlots];
  logic [47:0] tim_q  [NumSlots];
  logic [23:0] size_q [NumSlots];

  logic [CntW-1:0] pool_q;
  logic [31:0]     wr_cnt_q, drop_cnt_q;
  logic [2:0]      grow_cnt_q;

  logic [1:0]  cmd_q;
  logic [31:0] fseq_q;
  logic [47:0] ftim_q;
  logic [23:0] fbytes_q;
  logic [3:0]  rel_q;

  logic [SlotW-1:0] idx_q;
  logic             dropped_q;
  // Write search: first empty, lowest-sequence ready, first free.
  logic             emp_f_q, rdy_f_q, free_f_q;
  logic [SlotW-1:0] emp_i_q, rdy_i_q, free_i_q;
  logic [31:0]      rdy_seq_q;
  // Acquire search.
  logic             acq_f_q;
  logic [SlotW-1:0] acq_i_q;
  logic [47:0]      acq_t_q;
  // Statistics.
  logic [CntW-1:0]  used_q;
  logic [28:0]      bytes_q;

  logic [SlotW-1:0] i;
  logic             last;
  logic             in_pool, used_i;

  assign i       = idx_q;
  assign last    = (CntW'(idx_q) == pool_q - CntW'(1));
  assign in_pool = (CntW'(idx_q) < pool_q);
  assign used_i  = (st_q[i] == SLOT_READY) || (st_q[i] == SLOT_READING);
  assign sts_o.scan_last = last;
  assign sts_o.stat_last = last;

  logic [CntW:0] dbl;
  assign dbl = {pool_q, 1'b0};

  logic [1:0]       r_status;
  logic [SlotW-1:0] r_slot;
  logic             w_ok;
  logic [SlotW-1:0] w_tgt;

  always_comb begin
    w_ok  = emp_f_q || rdy_f_q || free_f_q;
    w_tgt = emp_f_q ? emp_i_q : (rdy_f_q ? rdy_i_q : free_i_q);
  end

  logic [1:0]  res_status_q;
  logic [3:0]  res_slot_q;
  logic [31:0] res_seq_q;
  logic [47:0] res_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSlots; k++) begin
        st_q[k]   <= SLOT_EMPTY;
        rd_q[k]   <= '0;
        seq_q[k]  <= '0;
        tim_q[k]  <= '0;
        size_q[k] <= '0;
      end
      pool_q       <= CntW'(4);
      wr_cnt_q     <= '0;
      drop_cnt_q   <= '0;
      grow_cnt_q   <= '0;
      idx_q        <= '0;
      dropped_q    <= 1'b0;
      emp_f_q      <= 1'b0;
      rdy_f_q      <= 1'b0;
      free_f_q     <= 1'b0;
      acq_f_q      <= 1'b0;
      used_q       <= '0;
      bytes_q      <= '0;
      res_status_q <= '0;
      res_slot_q   <= '0;
      res_seq_q    <= '0;
      res_time_q   <= '0;
    end else begin
      if (cfg_slots_we_i) begin
        pool_q <= clamp_slots(cfg_slots_i);
      end
      if (cmd_i.load) begin
        cmd_q     <= command_i;
        fseq_q    <= frame_sequence_i;
        ftim_q    <= frame_time_i;
        fbytes_q  <= frame_bytes_i;
        rel_q     <= release_slot_i;
        idx_q     <= '0;
        used_q    <= '0;
        bytes_q   <= '0;
        dropped_q <= 1'b0;
      end
      if (cmd_i.stat) begin
        if (in_pool && used_i) begin
          used_q <= used_q + CntW'(1);
        end
        if (in_pool && st_q[i] != SLOT_EMPTY) begin
          bytes_q <= bytes_q + 29'(size_q[i]);
        end
        idx_q <= last ? '0 : idx_q + SlotW'(1);
      end
      if (cmd_i.prepare) begin
        emp_f_q  <= 1'b0;
        rdy_f_q  <= 1'b0;
        free_f_q <= 1'b0;
        acq_f_q  <= 1'b0;
        idx_q    <= '0;
        if (cmd_q == CMD_WRITE && recording_i && used_q >= pool_q) begin
          if ({4'd0, bytes_q} + 33'(fbytes_q) < 33'(byte_budget_i)) begin
            if (dbl <= (CntW + 1)'(NumSlots)) begin
              for (int k = 0; k < NumSlots; k++) begin
                if (CntW'(k) >= pool_q && (CntW + 1)'(k) < dbl) begin
                  st_q[k]   <= SLOT_EMPTY;
                  rd_q[k]   <= '0;
                  seq_q[k]  <= '0;
                  tim_q[k]  <= '0;
                  size_q[k] <= '0;
                end
              end
              pool_q     <= dbl[CntW-1:0];
              grow_cnt_q <= grow_cnt_q + 3'd1;
            end
          end else begin
            dropped_q <= 1'b1;
          end
        end
      end
      if (cmd_i.scan) begin
        idx_q <= last ? '0 : idx_q + SlotW'(1);
        if (!emp_f_q && st_q[i] == SLOT_EMPTY) begin
          emp_f_q <= 1'b1;
          emp_i_q <= i;
        end
        if (st_q[i] == SLOT_READY && rd_q[i] == '0 &&
            (!rdy_f_q || seq_q[i] < rdy_seq_q)) begin
          rdy_f_q   <= 1'b1;
          rdy_i_q   <= i;
          rdy_seq_q <= seq_q[i];
        end
        if (!free_f_q && rd_q[i] == '0) begin
          free_f_q <= 1'b1;
          free_i_q <= i;
        end
        if (used_i && (!acq_f_q || tim_q[i] > acq_t_q)) begin
          acq_f_q <= 1'b1;
          acq_i_q <= i;
          acq_t_q <= tim_q[i];
        end
      end
      if (cmd_i.commit) begin
        res_status_q <= STS_DONE;
        res_slot_q   <= '0;
        res_seq_q    <= '0;
        res_time_q   <= '0;
        used_q       <= '0;
        bytes_q      <= '0;
        idx_q        <= '0;
        case (cmd_q)
          CMD_WRITE: begin
            if (dropped_q || !w_ok) begin
              res_status_q <= STS_DROPPED;
              drop_cnt_q   <= drop_cnt_q + 32'd1;
            end else begin
              st_q[w_tgt]   <= SLOT_READY;
              seq_q[w_tgt]  <= fseq_q;
              tim_q[w_tgt]  <= ftim_q;
              size_q[w_tgt] <= fbytes_q;
              wr_cnt_q      <= wr_cnt_q + 32'd1;
              res_slot_q    <= w_tgt;
            end
          end
          CMD_ACQUIRE: begin
            if (acq_f_q) begin
              if (rd_q[acq_i_q] != 8'hFF) begin
                rd_q[acq_i_q] <= rd_q[acq_i_q] + 8'd1;
              end
              st_q[acq_i_q] <= SLOT_READING;
              res_slot_q    <= acq_i_q;
              res_seq_q     <= seq_q[acq_i_q];
              res_time_q    <= tim_q[acq_i_q];
            end else begin
              res_status_q <= STS_NOFRAME;
            end
          end
          CMD_RELEASE: begin
            if (CntW'(rel_q) >= pool_q) begin
              res_status_q <= STS_IGNORED;
            end else if (rd_q[rel_q] != '0) begin
              rd_q[rel_q] <= rd_q[rel_q] - 8'd1;
              if (rd_q[rel_q] == 8'd1) begin
                st_q[rel_q] <= SLOT_READY;
              end
            end else if (st_q[rel_q] == SLOT_READING) begin
              st_q[rel_q] <= SLOT_READY;
            end
          end
          default: begin
            for (int k = 0; k < NumSlots; k++) begin
              if (CntW'(k) < pool_q && rd_q[k] == '0) begin
                st_q[k]   <= SLOT_EMPTY;
                seq_q[k]  <= '0;
                tim_q[k]  <= '0;
                size_q[k] <= '0;
              end
            end
          end
        endcase
      end
    end
  end

  assign r_status = res_status_q;
  assign r_slot   = res_slot_q;

  // Result packing, low to high: status, slot, sequence, time, active, used,
  // bytes, written, dropped, growth.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_o <= {grow_cnt_q, drop_cnt_q, wr_cnt_q, bytes_q[27:0], used_q, pool_q,
                   res_time_q, res_seq_q, r_slot, r_status};
    end
  end

endmodule

[rtl/frame_slot_manager.sv]
// ----------------------------------------------------------------------------
// frame_slot_manager: metadata manager for a pool of up to sixteen frame slots.
// ----------------------------------------------------------------------------
// Each request makes a statistics pass over the N active slots, a growth
// decision, a pass over the M active slots after growth for the slot searches,
// a commit, a second statistics pass over the M slots and a load of the result
// register; all passes share the single slot scan unit. A finished result waits
// in its own register; the next request is taken only after that result has
// left the block.
module frame_slot_manager (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: command[1:0], frame_sequence[33:2], frame_time[81:34],
  // frame_bytes[105:82], release_slot[109:106], zero fill to 112.
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], slot_out[5:2], sequence_out[37:6], time_out[85:38],
  // active_slots[90:86], slots_in_use[95:91], bytes_in_use[123:96],
  // written_total[155:124], dropped_total[187:156], growth_total[190:188].
  output logic [191:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import fsm_pkg::*;

  fsm_pkg::dp_cmd_t cmd;
  fsm_pkg::dp_sts_t sts;
  logic busy, in_fire, out_v_q;
  logic [190:0] res;
  logic [4:0]  init_slots_q;
  logic [31:0] budget_q;
  logic        rec_q;
  logic        wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy && !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_slots_q <= 5'd4;
      budget_q     <= 32'h1000_0000;
      rec_q        <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (wr_en && paddr == {ADDR_INIT_SLOTS, 2'b00}) init_slots_q <= pwdata[4:0];
      if (wr_en && paddr == {ADDR_BUDGET, 2'b00}) budget_q <= pwdata;
      if (wr_en && paddr == {ADDR_RECORDING, 2'b00}) rec_q <= pwdata[0];
      if (cmd.finish) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (paddr)
      {ADDR_INIT_SLOTS, 2'b00}: prdata = {27'd0, init_slots_q};
      {ADDR_BUDGET, 2'b00}:     prdata = budget_q;
      {ADDR_RECORDING, 2'b00}:  prdata = {31'd0, rec_q};
      default:                  prdata = '0;
    endcase
  end

  fsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (!out_v_q),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  fsm_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .command_i        (s_axis_tdata[1:0]),
    .frame_sequence_i (s_axis_tdata[33:2]),
    .frame_time_i     (s_axis_tdata[81:34]),
    .frame_bytes_i    (s_axis_tdata[105:82]),
    .release_slot_i   (s_axis_tdata[109:106]),
    .cfg_slots_we_i   (wr_en && paddr == {ADDR_INIT_SLOTS, 2'b00}),
    .cfg_slots_i      (pwdata[4:0]),
    .byte_budget_i    (budget_q),
    .recording_i      (rec_q),
    .result_o         (res)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {1'b0, res};

endmodule

[rtl/fsm_checker.sv]
// ----------------------------------------------------------------------------
// fsm_checker: port-level checks of the frame slot manager.
// ----------------------------------------------------------------------------
module fsm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata
);
  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while result held");
  a_take_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("accept not busy");
  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[90:86] != 5'd0 && m_axis_tdata[90:86] <= 5'd16))
    else $error("active slots out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
endmodule

bind frame_slot_manager fsm_checker u_fsm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[sim/frame_slot_manager_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_slot_manager_tb: self-checking bench for the frame slot manager.
// Drives write, acquire, release and clear requests with random stalls on
// both stream sides, predicts every result item from a behavioral copy of
// the slot pool and compares all result fields in order.
// ----------------------------------------------------------------------------
module frame_slot_manager_tb;
  import fsm_pkg::*;

  typedef struct packed {
    logic [3:0]  rel;
    logic [23:0] bytes;
    logic [47:0] tstamp;
    logic [31:0] seq;
    cmd_e        cmd;
  } request_t;

  typedef struct packed {
    logic [2:0]  grows;
    logic [31:0] drops;
    logic [31:0] writes;
    logic [27:0] bytes_used;
    logic [4:0]  used;
    logic [4:0]  active;
    logic [47:0] tstamp;
    logic [31:0] seq;
    logic [3:0]  slot;
    status_e     status;
  } result_t;

  logic         clk_i, rst_ni;
  logic         s_axis_tvalid, s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid, m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic         psel, penable, pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata, prdata;
  logic         pready;

  frame_slot_manager dut (.*);

  // Predicted pool state.
  slot_state_e p_state [NumSlots];
  logic [7:0]  p_readers [NumSlots];
  logic [31:0] p_seq [NumSlots];
  logic [47:0] p_time [NumSlots];
  logic [23:0] p_size [NumSlots];
  int unsigned p_slots, p_budget;
  bit          p_recording;
  logic [31:0] p_writes, p_drops;
  logic [2:0]  p_grows;

  request_t    pending_requests[$];
  result_t     expected_results[$];
  int          failures = 0;
  int unsigned cycle = 0;
  bit          quiet_phase = 0;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void empty_pool_slot(int i);
    p_state[i] = SLOT_EMPTY;
    p_readers[i] = 0;
    p_seq[i] = 0;
    p_time[i] = 0;
    p_size[i] = 0;
  endfunction

  function automatic int unsigned used_slots();
    int unsigned n = 0;
    for (int i = 0; i < p_slots; i++) if (p_state[i] != SLOT_EMPTY) n++;
    return n;
  endfunction

  function automatic longint unsigned stored_bytes();
    longint unsigned b = 0;
    for (int i = 0; i < p_slots; i++) if (p_state[i] != SLOT_EMPTY) b += p_size[i];
    return b;
  endfunction

  function automatic status_e store_frame(request_t r, output logic [3:0] slot);
    int target = -1;
    logic [31:0] min_seq = 0;
    slot = 0;
    if (p_recording && used_slots() >= p_slots) begin
      if (stored_bytes() + r.bytes < longint'(p_budget)) begin
        if (p_slots * 2 <= NumSlots) begin
          for (int i = p_slots; i < p_slots * 2; i++) empty_pool_slot(i);
          p_slots = p_slots * 2;
          p_grows++;
        end
      end else begin
        p_drops++;
        return STS_DROPPED;
      end
    end
    for (int i = 0; i < p_slots; i++) begin
      if (p_state[i] == SLOT_EMPTY) begin
        target = i;
        break;
      end
      if (p_state[i] == SLOT_READY && p_readers[i] == 0 &&
          (target < 0 || p_seq[i] < min_seq)) begin
        min_seq = p_seq[i];
        target = i;
      end
    end
    if (target < 0) begin
      for (int i = 0; i < p_slots; i++) begin
        if (p_readers[i] == 0) begin
          target = i;
          break;
        end
      end
    end
    if (target < 0) begin
      p_drops++;
      return STS_DROPPED;
    end
    p_state[target] = SLOT_READY;
    p_seq[target] = r.seq;
    p_time[target] = r.tstamp;
    p_size[target] = r.bytes;
    p_writes++;
    slot = 4'(target);
    return STS_DONE;
  endfunction

  function automatic result_t predict_result(request_t r);
    result_t res;
    int best = -1;
    res = '0;
    res.status = STS_DONE;
    case (r.cmd)
      CMD_WRITE: res.status = store_frame(r, res.slot);
      CMD_ACQUIRE: begin
        for (int i = 0; i < p_slots; i++)
          if (p_state[i] != SLOT_EMPTY && (best < 0 || p_time[i] > p_time[best])) best = i;
        if (best >= 0) begin
          if (p_readers[best] != 8'hff) p_readers[best]++;
          p_state[best] = SLOT_READING;
          res.slot = 4'(best);
          res.seq = p_seq[best];
          res.tstamp = p_time[best];
        end else begin
          res.status = STS_NOFRAME;
        end
      end
      CMD_RELEASE: begin
        if (r.rel >= p_slots) begin
          res.status = STS_IGNORED;
        end else if (p_readers[r.rel] > 0) begin
          p_readers[r.rel]--;
          if (p_readers[r.rel] == 0) p_state[r.rel] = SLOT_READY;
        end else if (p_state[r.rel] == SLOT_READING) begin
          p_state[r.rel] = SLOT_READY;
        end
      end
      default: begin
        for (int i = 0; i < p_slots; i++) if (p_readers[i] == 0) empty_pool_slot(i);
      end
    endcase
    res.active = 5'(p_slots);
    res.used = 5'(used_slots());
    res.bytes_used = 28'(stored_bytes());
    res.writes = p_writes;
    res.drops = p_drops;
    res.grows = p_grows;
    return res;
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_requests.size() > 0 && (quiet_phase || $urandom_range(99) >= 21)) begin
        request_t r;
        r = pending_requests.pop_front();
        expected_results = {expected_results, predict_result(r)};
        s_axis_tdata <= {2'b00, r};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_t got, want;
        got = m_axis_tdata[190:0];
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); failures++;
          end
          if (got.slot !== want.slot) begin
            $error("slot_out: expected %0d, got %0d", want.slot, got.slot); failures++;
          end
          if (got.seq !== want.seq) begin
            $error("sequence_out: expected %0h, got %0h", want.seq, got.seq); failures++;
          end
          if (got.tstamp !== want.tstamp) begin
            $error("time_out: expected %0h, got %0h", want.tstamp, got.tstamp); failures++;
          end
          if (got.active !== want.active) begin
            $error("active_slots: expected %0d, got %0d", want.active, got.active);
            failures++;
          end
          if (got.used !== want.used) begin
            $error("slots_in_use: expected %0d, got %0d", want.used, got.used); failures++;
          end
          if (got.bytes_used !== want.bytes_used) begin
            $error("bytes_in_use: expected %0d, got %0d", want.bytes_used, got.bytes_used);
            failures++;
          end
          if (got.writes !== want.writes) begin
            $error("written_total: expected %0d, got %0d", want.writes, got.writes);
            failures++;
          end
          if (got.drops !== want.drops) begin
            $error("dropped_total: expected %0d, got %0d", want.drops, got.drops);
            failures++;
          end
          if (got.grows !== want.grows) begin
            $error("growth_total: expected %0d, got %0d", want.grows, got.grows);
            failures++;
          end
        end
      end
      m_axis_tready <= quiet_phase || $urandom_range(99) >= 21;
    end
  end

  task automatic write_register(reg_addr_e addr, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {addr, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_INIT_SLOTS: begin
        p_slots = (value[4:0] == 0) ? 1 : (value[4:0] > NumSlots) ? NumSlots : value[4:0];
      end
      ADDR_BUDGET: p_budget = value;
      default: p_recording = value[0];
    endcase
  endtask

  task automatic queue_request(cmd_e cmd, logic [31:0] seq, logic [47:0] tstamp,
                               logic [23:0] bytes, logic [3:0] rel);
    request_t r;
    r.cmd = cmd;
    r.seq = seq;
    r.tstamp = tstamp;
    r.bytes = bytes;
    r.rel = rel;
    pending_requests = {pending_requests, r};
  endtask

  task automatic queue_random(int n, int max_bytes);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      queue_request(pick < 45 ? CMD_WRITE : pick < 70 ? CMD_ACQUIRE :
                    pick < 95 ? CMD_RELEASE : CMD_CLEAR,
                    $urandom, {4'($urandom_range(15)), 12'd0, 32'($urandom)},
                    24'($urandom_range(max_bytes)), 4'($urandom_range(15)));
    end
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    rst_ni = 0;
    p_slots = 4; p_budget = 32'h1000_0000; p_recording = 0;
    p_writes = 0; p_drops = 0; p_grows = 0;
    for (int i = 0; i < NumSlots; i++) empty_pool_slot(i);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty acquire, field extremes, releases in and out of range, clear.
    queue_request(CMD_ACQUIRE, 0, 0, 0, 0);
    queue_request(CMD_WRITE, 32'hffff_ffff, 48'hffff_ffff_ffff, 24'hff_ffff, 4'hf);
    queue_request(CMD_WRITE, 0, 0, 0, 0);
    queue_request(CMD_WRITE, 5, 48'h10, 100, 0);
    queue_request(CMD_WRITE, 3, 48'h10, 100, 0);
    queue_request(CMD_WRITE, 9, 48'h20, 7, 0);
    queue_request(CMD_ACQUIRE, 0, 0, 0, 0);
    queue_request(CMD_RELEASE, 0, 0, 0, 4'hf);
    queue_request(CMD_RELEASE, 0, 0, 0, 0);
    queue_request(CMD_RELEASE, 0, 0, 0, 0);
    queue_request(CMD_ACQUIRE, 0, 0, 0, 0);
    queue_request(CMD_CLEAR, 0, 0, 0, 0);
    queue_request(CMD_RELEASE, 0, 0, 0, 0);
    queue_request(CMD_CLEAR, 0, 0, 0, 0);
    drain();

    // Recording with growth, then full pool at sixteen slots.
    write_register(ADDR_RECORDING, 1);
    write_register(ADDR_INIT_SLOTS, 1);
    for (int k = 0; k < 20; k++) queue_request(CMD_WRITE, k, k, 1000, 0);
    drain();
    // Reader saturation on the latest frame.
    for (int k = 0; k < 260; k++) queue_request(CMD_ACQUIRE, 0, 0, 0, 0);
    queue_request(CMD_WRITE, 1, 1, 1, 0);
    queue_random(60, 16777215);
    drain();

    // Budget drop, zero slots clamp, oversize clamp.
    write_register(ADDR_BUDGET, 0);
    write_register(ADDR_INIT_SLOTS, 0);
    queue_random(110, 16777215);
    drain();
    write_register(ADDR_INIT_SLOTS, 31);
    write_register(ADDR_BUDGET, 32'hffff_ffff);
    queue_random(110, 4000);
    drain();
    write_register(ADDR_RECORDING, 0);
    write_register(ADDR_INIT_SLOTS, $urandom_range(1, 16));
    queue_random(110, 16777215);
    drain();
    write_register(ADDR_RECORDING, 1);
    write_register(ADDR_BUDGET, 50000);
    write_register(ADDR_INIT_SLOTS, 2);
    quiet_phase = 1;
    queue_random(110, 20000);
    drain();
    quiet_phase = 0;
    write_register(ADDR_INIT_SLOTS, 3);
    queue_random(110, 30000);
    drain();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fsm_pkg.sv
rtl/fsm_ctrl.sv
rtl/fsm_dp.sv
rtl/frame_slot_manager.sv
rtl/fsm_checker.sv
sim/frame_slot_manager_tb.sv
